FILE: rtl/fixv_pkg.sv
// ----------------------------------------------------------------------------
// fixv_pkg
// Shared types and constants for the tag=value message validator.
// ----------------------------------------------------------------------------
package fixv_pkg;

   localparam int unsigned DEFAULT_MAX_BODY_BYTES = 65535;

   // Characters that steer the parser
   localparam logic [7:0] CHAR_SOH   = 8'h01;
   localparam logic [7:0] CHAR_EQ    = 8'h3D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Byte sum of the text "10=", taken back out when tag 10 is recognized
   localparam logic [7:0] TAG10_BYTES_SUM = 8'd158;

   localparam logic [9:0] TAG_BAD   = 10'd1023;
   localparam logic [9:0] TAG_LEN   = 10'd9;
   localparam logic [9:0] TAG_SUM   = 10'd10;
   localparam logic [9:0] SUM_CHARS = 10'd3;

   localparam int unsigned VERSION_BYTES = 8;

   // Configuration register indexes
   localparam logic CSR_VERSION_CHARS  = 1'b0;
   localparam logic CSR_VERSION_LENGTH = 1'b1;

   typedef enum logic [2:0] {
      PH_BEGIN_TAG,
      PH_BEGIN_VALUE,
      PH_TAG,
      PH_OTHER_VALUE,
      PH_LEN_VALUE,
      PH_SUM_VALUE,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic stop;    // digit run of the current value has ended
      logic tag10;   // tag 10 found, byte sum frozen
      logic body;    // body bytes are being counted
      logic tag9;    // tag 9 found
   } flags_type;

   typedef struct packed {
      logic       message_valid;
      logic       version_ok;
      logic       length_ok;
      logic       checksum_ok;
      logic [7:0] computed_checksum;
   } verdict_type;

endpackage

FILE: rtl/fixv_parse.sv
// ----------------------------------------------------------------------------
// fixv_parse
// Byte parser: tracks tags, version text, body length and byte sum, and
// forms the verdict for the byte that closes a message.
// ----------------------------------------------------------------------------
module fixv_parse
   import fixv_pkg::*;
#(
   parameter int unsigned MAX_BODY_BYTES = DEFAULT_MAX_BODY_BYTES
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  data_byte,
   input  logic        final_byte,
   input  logic [63:0] version_chars,
   input  logic [3:0]  version_length,
   output verdict_type verdict
);

   localparam int unsigned LEN_W = $clog2(MAX_BODY_BYTES + 5);
   localparam int unsigned PW    = LEN_W + 4;
   localparam logic [PW-1:0]    LEN_LIMIT  = PW'(MAX_BODY_BYTES);
   localparam logic [LEN_W-1:0] LEN_MAX    = LEN_W'(MAX_BODY_BYTES);
   localparam logic [LEN_W-1:0] LEN_OVER   = LEN_W'(MAX_BODY_BYTES + 1);
   localparam logic [LEN_W-1:0] CNT_SAT    = LEN_W'(MAX_BODY_BYTES + 4);
   localparam logic [LEN_W-1:0] CNT_SUB_OK = LEN_W'(MAX_BODY_BYTES + 3);
   localparam logic [LEN_W-1:0] CNT_THREE  = LEN_W'(3);

   phase_type          phase_ff, phase_in, phase_nx;
   logic [7:0]         sum_ff, sum_in, sum_nx, sum_a;
   logic [9:0]         tag_ff, tag_in, tag_nx;
   logic [3:0]         vidx_ff, vidx_in, vidx_nx;
   logic               vmatch_ff, vmatch_in, vmatch_nx;
   logic [LEN_W-1:0]   dlen_ff, dlen_in, dlen_nx;
   logic [LEN_W-1:0]   bcnt_ff, bcnt_in, bcnt_nx, bcnt_a;
   logic [9:0]         dsum_ff, dsum_in, dsum_nx;
   flags_type          flags_ff, flags_in, flags_nx;

   logic               is_soh, is_eq, is_dig, frozen;
   logic               tag_eq, tag9_hit, tag10_hit, run_digit;
   logic [3:0]         digit;
   logic [7:0]         vsel;
   logic [13:0]        tag_mac, dsum_mac;
   logic [PW-1:0]      dlen_mac;
   logic               have10, v_ok, l_ok, c_ok;

   assign is_soh    = (data_byte == CHAR_SOH);
   assign is_eq     = (data_byte == CHAR_EQ);
   assign is_dig    = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign digit     = data_byte[3:0];
   assign frozen    = flags_ff.tag10;
   assign run_digit = is_dig && !flags_ff.stop;

   assign tag_eq    = (phase_ff == PH_TAG) && is_eq;
   assign tag9_hit  = tag_eq && (tag_ff == TAG_LEN) && !flags_ff.tag9 && !flags_ff.tag10;
   assign tag10_hit = tag_eq && (tag_ff == TAG_SUM) && !frozen;

   assign vsel = version_chars[{vidx_ff[2:0], 3'b000} +: 8];

   // value = value * 10 + digit, as shifts and adds
   assign tag_mac  = ({4'b0, tag_ff} << 3) + ({4'b0, tag_ff} << 1) + {10'b0, digit};
   assign dsum_mac = ({4'b0, dsum_ff} << 3) + ({4'b0, dsum_ff} << 1) + {10'b0, digit};
   assign dlen_mac = ({4'b0, dlen_ff} << 3) + ({4'b0, dlen_ff} << 1)
                     + {{(PW-4){1'b0}}, digit};

   // next phase
   always_comb begin
      phase_nx = phase_ff;
      unique case (phase_ff)
         PH_BEGIN_TAG: begin
            if (is_eq) phase_nx = PH_BEGIN_VALUE;
            else if (is_soh) phase_nx = PH_TAG;
         end
         PH_BEGIN_VALUE: begin
            if (is_soh) phase_nx = PH_TAG;
         end
         PH_TAG: begin
            if (is_eq) begin
               if (tag9_hit) phase_nx = PH_LEN_VALUE;
               else if (tag10_hit) phase_nx = PH_SUM_VALUE;
               else phase_nx = PH_OTHER_VALUE;
            end
         end
         PH_OTHER_VALUE, PH_LEN_VALUE: begin
            if (is_soh) phase_nx = PH_TAG;
         end
         PH_SUM_VALUE: begin
            if (is_soh || (tag_ff + 10'd1 >= SUM_CHARS)) phase_nx = PH_DONE;
         end
         PH_DONE: phase_nx = PH_DONE;
         default: phase_nx = PH_BEGIN_TAG;
      endcase
   end

   // datapath next values
   always_comb begin
      tag_nx    = tag_ff;
      vidx_nx   = vidx_ff;
      vmatch_nx = vmatch_ff;
      dlen_nx   = dlen_ff;
      dsum_nx   = dsum_ff;
      flags_nx  = flags_ff;

      sum_a  = frozen ? sum_ff : sum_ff + data_byte;
      bcnt_a = bcnt_ff;
      if (!frozen && flags_ff.body && (bcnt_ff < CNT_SAT)) bcnt_a = bcnt_ff + 1'b1;
      sum_nx  = sum_a;
      bcnt_nx = bcnt_a;

      case (phase_ff)
         PH_BEGIN_TAG: begin
            if (!is_eq && is_soh) begin
               vmatch_nx = 1'b0;
               tag_nx    = '0;
            end
         end
         PH_BEGIN_VALUE: begin
            if (is_soh) begin
               vmatch_nx = vmatch_ff && (vidx_ff == version_length)
                           && (version_length <= 4'(VERSION_BYTES));
               tag_nx = '0;
            end else if (vidx_ff < 4'(VERSION_BYTES)) begin
               if (vsel != data_byte) vmatch_nx = 1'b0;
               vidx_nx = vidx_ff + 1'b1;
            end else begin
               vmatch_nx = 1'b0;
            end
         end
         PH_TAG: begin
            if (is_soh) begin
               tag_nx = '0;
            end else if (is_eq) begin
               if (tag9_hit) begin
                  flags_nx.tag9 = 1'b1;
                  flags_nx.stop = 1'b0;
                  dlen_nx       = '0;
               end else if (tag10_hit) begin
                  flags_nx.tag10 = 1'b1;
                  flags_nx.stop  = 1'b0;
                  sum_nx         = sum_a - TAG10_BYTES_SUM;
                  if (flags_ff.body && (bcnt_a <= CNT_SUB_OK)) bcnt_nx = bcnt_a - CNT_THREE;
                  dsum_nx = '0;
                  tag_nx  = '0;
               end
            end else if (is_dig && (tag_ff != TAG_BAD)
                         && !((tag_ff == '0) && (digit == 4'd0))) begin
               tag_nx = (tag_mac > 14'(TAG_BAD)) ? TAG_BAD : tag_mac[9:0];
            end else begin
               tag_nx = TAG_BAD;
            end
         end
         PH_OTHER_VALUE: begin
            if (is_soh) tag_nx = '0;
         end
         PH_LEN_VALUE: begin
            if (is_soh) begin
               flags_nx.body = 1'b1;
               tag_nx        = '0;
            end else if (run_digit) begin
               dlen_nx = (dlen_mac > LEN_LIMIT) ? LEN_OVER : dlen_mac[LEN_W-1:0];
            end else begin
               flags_nx.stop = 1'b1;
            end
         end
         PH_SUM_VALUE: begin
            if (!is_soh) begin
               if (run_digit) dsum_nx = dsum_mac[9:0];
               else flags_nx.stop = 1'b1;
               tag_nx = tag_ff + 10'd1;
            end
         end
         default: ;
      endcase
   end

   // a final word returns the parser to the start of a message
   always_comb begin
      if (final_byte) begin
         phase_in  = PH_BEGIN_TAG;
         sum_in    = '0;
         tag_in    = '0;
         vidx_in   = '0;
         vmatch_in = 1'b1;
         dlen_in   = '0;
         bcnt_in   = '0;
         dsum_in   = '0;
         flags_in  = '0;
      end else begin
         phase_in  = phase_nx;
         sum_in    = sum_nx;
         tag_in    = tag_nx;
         vidx_in   = vidx_nx;
         vmatch_in = vmatch_nx;
         dlen_in   = dlen_nx;
         bcnt_in   = bcnt_nx;
         dsum_in   = dsum_nx;
         flags_in  = flags_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_BEGIN_TAG;
         sum_ff    <= '0;
         tag_ff    <= '0;
         vidx_ff   <= '0;
         vmatch_ff <= 1'b1;
         dlen_ff   <= '0;
         bcnt_ff   <= '0;
         dsum_ff   <= '0;
         flags_ff  <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         tag_ff    <= tag_in;
         vidx_ff   <= vidx_in;
         vmatch_ff <= vmatch_in;
         dlen_ff   <= dlen_in;
         bcnt_ff   <= bcnt_in;
         dsum_ff   <= dsum_in;
         flags_ff  <= flags_in;
      end
   end

   assign have10 = flags_nx.tag10;
   assign v_ok   = (phase_nx != PH_BEGIN_TAG) && (phase_nx != PH_BEGIN_VALUE) && vmatch_nx;
   assign l_ok   = have10 && flags_nx.body && (dlen_nx <= LEN_MAX) && (dlen_nx == bcnt_nx);
   assign c_ok   = have10 && (dsum_nx == {2'b00, sum_nx});

   assign verdict.message_valid     = v_ok && l_ok && c_ok;
   assign verdict.version_ok        = v_ok;
   assign verdict.length_ok         = l_ok;
   assign verdict.checksum_ok       = c_ok;
   assign verdict.computed_checksum = have10 ? sum_nx : 8'h00;

endmodule

FILE: rtl/fix_message_validator.sv
// ----------------------------------------------------------------------------
// fix_message_validator
// Checks version, body length and checksum of a tag=value message fed one
// byte per word, and returns one verdict word per message.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake             | payload
//  req_     | in        | req_valid / req_ready | data_byte, final_byte
//  rsp_     | out       | rsp_valid / rsp_ready | verdict flags, computed checksum
//  csr_     | in        | csr_valid / csr_ready | csr_index, csr_data
//
// One byte per cycle unless a final byte stalls. A byte sits in the input register,
// where the parser consumes it; the verdict of a final byte appears in the result
// register on the next cycle. Only a final byte waits on a full, stalled
// result register; other bytes keep flowing. Reset clears the parser, the
// handshake registers and both configuration registers. csr_ready is always high.
module fix_message_validator
   import fixv_pkg::*;
#(
   parameter int unsigned MAX_BODY_BYTES = DEFAULT_MAX_BODY_BYTES
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_message_valid,
   output logic        rsp_version_ok,
   output logic        rsp_length_ok,
   output logic        rsp_checksum_ok,
   output logic [7:0]  rsp_computed_checksum,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_final_ff;
   logic        rsp_valid_ff;
   verdict_type rsp_ff;
   logic [63:0] version_chars_ff;
   logic [3:0]  version_length_ff;

   logic        req_fire, advance;
   verdict_type verdict;

   assign req_fire  = req_valid && req_ready;
   // a buffered byte moves on unless it is a final byte facing a stalled result
   assign advance   = in_valid_ff && (!in_final_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_fire) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff  <= req_data_byte;
         in_final_ff <= req_final_byte;
      end
   end

   fixv_parse #(
      .MAX_BODY_BYTES(MAX_BODY_BYTES)
   ) u_parse (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .data_byte      (in_byte_ff),
      .final_byte     (in_final_ff),
      .version_chars  (version_chars_ff),
      .version_length (version_length_ff),
      .verdict        (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_final_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_final_ff) begin
         rsp_ff <= verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         version_chars_ff  <= '0;
         version_length_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_VERSION_CHARS:  version_chars_ff  <= csr_data;
            CSR_VERSION_LENGTH: version_length_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_message_valid     = rsp_ff.message_valid;
   assign rsp_version_ok        = rsp_ff.version_ok;
   assign rsp_length_ok         = rsp_ff.length_ok;
   assign rsp_checksum_ok       = rsp_ff.checksum_ok;
   assign rsp_computed_checksum = rsp_ff.computed_checksum;

endmodule

FILE: rtl/fixv_checker.sv
// ----------------------------------------------------------------------------
// fixv_checker
// Port-level checks for the message validator, bound to the top level.
// ----------------------------------------------------------------------------
module fixv_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_message_valid,
   input logic       rsp_version_ok,
   input logic       rsp_length_ok,
   input logic       rsp_checksum_ok,
   input logic [7:0] rsp_computed_checksum
);

   // a stalled verdict word stays valid, its checksum and message_valid held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_computed_checksum)
         && $stable(rsp_message_valid))
      else $error("verdict changed while stalled");

   a_verdict_and: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_message_valid ==
         (rsp_version_ok && rsp_length_ok && rsp_checksum_ok))
      else $error("message_valid disagrees with the three checks");

   // with no verdict pending the input side never blocks
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict valid after reset");

endmodule

bind fix_message_validator fixv_checker u_fixv_checker (
   .clock                 (clock),
   .reset                 (reset),
   .req_ready             (req_ready),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_message_valid     (rsp_message_valid),
   .rsp_version_ok        (rsp_version_ok),
   .rsp_length_ok         (rsp_length_ok),
   .rsp_checksum_ok       (rsp_checksum_ok),
   .rsp_computed_checksum (rsp_computed_checksum)
);

FILE: tb/sv/fixv_verdict_checker.sv
// ----------------------------------------------------------------------------
// fixv_verdict_checker
// Watches the byte, verdict and register channels of the message validator,
// runs its own parser on every accepted byte and compares each verdict word
// against the oldest expected one, field by field.
// ----------------------------------------------------------------------------
module fixv_verdict_checker
   import fixv_pkg::*;
#(
   parameter int unsigned MAX_BODY = DEFAULT_MAX_BODY_BYTES
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_final_byte,

   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_message_valid,
   input  logic        rsp_version_ok,
   input  logic        rsp_length_ok,
   input  logic        rsp_checksum_ok,
   input  logic [7:0]  rsp_computed_checksum,

   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [63:0] csr_data,

   output int          fail_count,
   output int          pending
);

   // register copies
   logic [63:0] want_chars;
   logic [3:0]  want_len;

   // parser copy
   phase_type   phase;
   logic [7:0]  sum;
   logic [9:0]  tag;
   logic [3:0]  ver_idx;
   logic        ver_ok;
   logic [16:0] decl_len;
   logic [16:0] body_cnt;
   logic [9:0]  decl_sum;
   flags_type   seen;

   verdict_type expected_verdicts[$];

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_error($sformatf("%s got %0d expected %0d", name, got, want));
      end
   endtask

   function automatic logic is_digit(input logic [7:0] b);
      return b >= CHAR_ZERO && b <= CHAR_NINE;
   endfunction

   task automatic clear_parser();
      phase    = PH_BEGIN_TAG;
      sum      = '0;
      tag      = '0;
      ver_idx  = '0;
      ver_ok   = 1'b1;
      decl_len = '0;
      body_cnt = '0;
      decl_sum = '0;
      seen     = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b);
      logic        frozen;
      int unsigned acc;
      frozen = seen.tag10;
      if (!frozen) begin
         sum = sum + b;
         if (seen.body && body_cnt < MAX_BODY + 4) begin
            body_cnt = body_cnt + 17'd1;
         end
      end
      case (phase)
         PH_BEGIN_TAG: begin
            if (b == CHAR_EQ) begin
               phase = PH_BEGIN_VALUE;
            end else if (b == CHAR_SOH) begin
               // no begin string at all
               ver_ok = 1'b0;
               phase  = PH_TAG;
               tag    = '0;
            end
         end
         PH_BEGIN_VALUE: begin
            if (b == CHAR_SOH) begin
               ver_ok = ver_ok && ver_idx == want_len && want_len <= VERSION_BYTES;
               phase  = PH_TAG;
               tag    = '0;
            end else if (ver_idx < VERSION_BYTES) begin
               if (want_chars[8*ver_idx +: 8] != b) begin
                  ver_ok = 1'b0;
               end
               ver_idx = ver_idx + 4'd1;
            end else begin
               ver_ok = 1'b0;
            end
         end
         PH_TAG: begin
            if (b == CHAR_SOH) begin
               tag = '0;
            end else if (b == CHAR_EQ) begin
               if (tag == TAG_LEN && !seen.tag9 && !seen.tag10) begin
                  seen.tag9 = 1'b1;
                  seen.stop = 1'b0;
                  decl_len  = '0;
                  phase     = PH_LEN_VALUE;
               end else if (tag == TAG_SUM && !frozen) begin
                  seen.tag10 = 1'b1;
                  seen.stop  = 1'b0;
                  // "10=" was summed and counted already, take it back out
                  sum = sum - TAG10_BYTES_SUM;
                  if (seen.body && body_cnt <= MAX_BODY + 3) begin
                     body_cnt = body_cnt - 17'd3;
                  end
                  decl_sum = '0;
                  tag      = '0;
                  phase    = PH_SUM_VALUE;
               end else begin
                  phase = PH_OTHER_VALUE;
               end
            end else if (is_digit(b) && tag != TAG_BAD && !(tag == 0 && b == CHAR_ZERO)) begin
               acc = tag;
               acc = acc * 10 + (b - CHAR_ZERO);
               tag = (acc > TAG_BAD) ? TAG_BAD : acc[9:0];
            end else begin
               tag = TAG_BAD;
            end
         end
         PH_OTHER_VALUE: begin
            if (b == CHAR_SOH) begin
               phase = PH_TAG;
               tag   = '0;
            end
         end
         PH_LEN_VALUE: begin
            if (b == CHAR_SOH) begin
               seen.body = 1'b1;
               phase     = PH_TAG;
               tag       = '0;
            end else if (is_digit(b) && !seen.stop) begin
               acc      = decl_len;
               acc      = acc * 10 + (b - CHAR_ZERO);
               decl_len = 17'((acc > MAX_BODY) ? MAX_BODY + 1 : acc);
            end else begin
               seen.stop = 1'b1;
            end
         end
         PH_SUM_VALUE: begin
            if (b == CHAR_SOH) begin
               phase = PH_DONE;
            end else begin
               if (is_digit(b) && !seen.stop) begin
                  acc      = decl_sum;
                  acc      = acc * 10 + (b - CHAR_ZERO);
                  decl_sum = acc[9:0];
               end else begin
                  seen.stop = 1'b1;
               end
               // tag counts value characters here
               tag = tag + 10'd1;
               if (tag >= SUM_CHARS) begin
                  phase = PH_DONE;
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic verdict_type message_verdict();
      verdict_type v;
      logic        have10;
      have10              = seen.tag10;
      v.version_ok        = (phase >= PH_TAG) && ver_ok;
      v.length_ok         = have10 && seen.body && decl_len <= MAX_BODY &&
                            decl_len == body_cnt;
      v.checksum_ok       = have10 && decl_sum == sum;
      v.message_valid     = v.version_ok && v.length_ok && v.checksum_ok;
      v.computed_checksum = have10 ? sum : 8'h00;
      return v;
   endfunction

   task automatic check_verdict();
      verdict_type want;
      if (expected_verdicts.size() == 0) begin
         report_error("verdict word with no message pending");
      end else begin
         want = expected_verdicts.pop_front();
         compare_field("message_valid", rsp_message_valid, want.message_valid);
         compare_field("version_ok", rsp_version_ok, want.version_ok);
         compare_field("length_ok", rsp_length_ok, want.length_ok);
         compare_field("checksum_ok", rsp_checksum_ok, want.checksum_ok);
         compare_field("computed_checksum", rsp_computed_checksum, want.computed_checksum);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         want_chars = '0;
         want_len   = '0;
         clear_parser();
         expected_verdicts.delete();
         pending <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_verdict();
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_VERSION_CHARS) begin
               want_chars = csr_data;
            end else begin
               want_len = csr_data[3:0];
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte);
            if (req_final_byte) begin
               expected_verdicts.push_back(message_verdict());
               clear_parser();
            end
         end
         pending <= expected_verdicts.size();
      end
   end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives tag=value messages into the validator one byte per word: a few
// directed words, then phases of random messages under different expected
// version strings, mostly well formed with one fault injected at a time.
// ----------------------------------------------------------------------------
module tb
   import fixv_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 10;
   localparam int PHASE_BYTES  = 190;
   localparam int DRAIN_CYCLES = 4;
   localparam int CALM_START   = 1200;
   localparam int CALM_END     = 2400;

   typedef enum int {
      FLT_NONE,
      FLT_BAD_VERSION,
      FLT_LONG_VERSION,
      FLT_SOH_FIRST,
      FLT_ODD_BEGIN_TAG,
      FLT_BAD_LENGTH,
      FLT_NO_LENGTH,
      FLT_ZERO_TAG,
      FLT_DUP_LENGTH,
      FLT_LEN_JUNK,
      FLT_EMPTY_LENGTH,
      FLT_HUGE_LENGTH,
      FLT_UNCLOSED_LENGTH,
      FLT_SUM_FIRST,
      FLT_BAD_SUM,
      FLT_SHORT_SUM,
      FLT_SUM_JUNK,
      FLT_NO_SUM,
      FLT_ZERO_SUM_TAG,
      FLT_TRAILING,
      FLT_NO_SOH_END,
      FLT_TRUNCATED,
      FLT_NOISE
   } fault_kind;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_final_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_message_valid;
   logic        rsp_version_ok;
   logic        rsp_length_ok;
   logic        rsp_checksum_ok;
   logic [7:0]  rsp_computed_checksum;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [63:0] csr_data;

   int          fail_count;
   int          pending;
   int          cycles;

   logic [63:0] cur_chars;
   logic [3:0]  cur_len;
   logic [7:0]  frame[$];

   fix_message_validator uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_final_byte        (req_final_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_message_valid     (rsp_message_valid),
      .rsp_version_ok        (rsp_version_ok),
      .rsp_length_ok         (rsp_length_ok),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_computed_checksum (rsp_computed_checksum),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   fixv_verdict_checker verdict_check (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_data_byte         (req_data_byte),
      .req_final_byte        (req_final_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_message_valid     (rsp_message_valid),
      .rsp_version_ok        (rsp_version_ok),
      .rsp_length_ok         (rsp_length_ok),
      .rsp_checksum_ok       (rsp_checksum_ok),
      .rsp_computed_checksum (rsp_computed_checksum),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .fail_count            (fail_count),
      .pending               (pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // no idling at all inside the calm window
   function automatic logic take_break();
      return (cycles < CALM_START || cycles >= CALM_END) && $urandom_range(0, 99) < 10;
   endfunction

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= !take_break();
      end
   end

   function automatic logic [7:0] print_char();
      logic [7:0] c;
      c = 8'($urandom_range(33, 126));
      return c;
   endfunction

   function automatic logic [7:0] any_byte();
      logic [7:0] c;
      c = 8'($urandom_range(0, 255));
      return c;
   endfunction

   function automatic logic [63:0] random_text(input bit full);
      logic [63:0] t;
      for (int i = 0; i < 8; i++) begin
         t[8*i +: 8] = full ? any_byte() : print_char();
      end
      return t;
   endfunction

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         frame.push_back(s[i]);
      end
   endtask

   task automatic put_checksum(input fault_kind flt);
      int unsigned acc;
      int unsigned sum_decl;
      int          jpos;
      string       txt;
      logic [7:0]  c;
      if (flt != FLT_NO_SUM) begin
         acc = 0;
         for (int i = 0; i < frame.size(); i++) begin
            acc += frame[i];
         end
         acc      = acc % 256;
         sum_decl = acc;
         if (flt == FLT_BAD_SUM) begin
            do sum_decl = $urandom_range(0, 999); while (sum_decl == acc);
         end
         put_text(flt == FLT_ZERO_SUM_TAG ? "010=" : "10=");
         txt  = (flt == FLT_SHORT_SUM) ? $sformatf("%0d", sum_decl) :
                                         $sformatf("%03d", sum_decl);
         jpos = (flt == FLT_SUM_JUNK) ? $urandom_range(0, txt.len() - 1) : -1;
         for (int i = 0; i < txt.len(); i++) begin
            c = (i == jpos) ? "z" : txt[i];
            frame.push_back(c);
         end
         if (flt != FLT_NO_SOH_END) begin
            frame.push_back(CHAR_SOH);
         end
      end
   endtask

   // one message into frame; big_body > 0 gives one long field of that many body bytes
   task automatic build_message(input fault_kind flt, input int big_body);
      logic [7:0]  tail[$];
      int unsigned n;
      int unsigned k;
      int          p;
      int unsigned len_decl;
      frame.delete();
      if (flt == FLT_NOISE) begin
         // parser characters dominate so the noise reaches past the first states
         n = $urandom_range(1, 30);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 7))
               0: frame.push_back(CHAR_SOH);
               1: frame.push_back(CHAR_EQ);
               2: frame.push_back("9");
               3: frame.push_back("1");
               4: frame.push_back("0");
               default: frame.push_back(any_byte());
            endcase
         end
      end else begin
         if (flt == FLT_SOH_FIRST) begin
            put_text("8");
         end else begin
            if (flt == FLT_ODD_BEGIN_TAG) begin
               n = $urandom_range(0, 3);
               for (int i = 0; i < n; i++) begin
                  frame.push_back(print_char());
               end
            end else begin
               put_text("8");
            end
            frame.push_back(CHAR_EQ);
            n = (cur_len > VERSION_BYTES) ? $urandom_range(0, 10) : cur_len;
            if (flt == FLT_LONG_VERSION) begin
               n = $urandom_range(9, 12);
            end
            p = frame.size();
            for (int i = 0; i < n; i++) begin
               frame.push_back(i < VERSION_BYTES ? cur_chars[8*i +: 8] : print_char());
            end
            if (flt == FLT_BAD_VERSION) begin
               if (n == 0) begin
                  frame.push_back(print_char());
               end else begin
                  p = p + $urandom_range(0, n - 1);
                  k = $urandom_range(1, 255);
                  frame[p] = frame[p] ^ k[7:0];
               end
            end
         end
         frame.push_back(CHAR_SOH);

         if (flt == FLT_SUM_FIRST) begin
            put_checksum(flt);
         end

         // body first, then lift it out so the length field can go ahead of it
         p = frame.size();
         if (big_body > 0) begin
            put_text("58=");
            for (int i = 0; i < big_body - 4; i++) begin
               frame.push_back("x");
            end
            frame.push_back(CHAR_SOH);
         end else begin
            n = $urandom_range(0, 4);
            for (int f = 0; f < n; f++) begin
               k = $urandom_range(1, 999);
               if (k == 9 || k == 10) begin
                  k = 11;
               end
               put_text($sformatf("%0d=", k));
               k = $urandom_range(0, 8);
               for (int i = 0; i < k; i++) begin
                  frame.push_back(print_char());
               end
               frame.push_back(CHAR_SOH);
            end
         end
         if (flt == FLT_DUP_LENGTH) begin
            put_text($sformatf("9=%0d", $urandom_range(0, 99)));
            frame.push_back(CHAR_SOH);
         end
         for (int i = p; i < frame.size(); i++) begin
            tail.push_back(frame[i]);
         end
         while (frame.size() > p) begin
            void'(frame.pop_back());
         end

         if (flt != FLT_NO_LENGTH) begin
            put_text(flt == FLT_ZERO_TAG ? "09=" : "9=");
            len_decl = tail.size();
            case (flt)
               FLT_BAD_LENGTH: begin
                  if (len_decl > 3 && $urandom_range(0, 1)) begin
                     len_decl = len_decl - $urandom_range(1, 3);
                  end else begin
                     len_decl = len_decl + $urandom_range(1, 3);
                  end
                  put_text($sformatf("%0d", len_decl));
               end
               FLT_LEN_JUNK: put_text($sformatf("%0dx7", len_decl));
               FLT_EMPTY_LENGTH: ;
               FLT_HUGE_LENGTH: put_text($sformatf("%0d", $urandom_range(100000, 999999999)));
               default: put_text($sformatf("%0d", len_decl));
            endcase
            if (flt != FLT_UNCLOSED_LENGTH) begin
               frame.push_back(CHAR_SOH);
            end
         end
         for (int i = 0; i < tail.size(); i++) begin
            frame.push_back(tail[i]);
         end

         if (flt != FLT_SUM_FIRST) begin
            put_checksum(flt);
         end
         if (flt == FLT_TRAILING) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) begin
               frame.push_back(any_byte());
            end
         end
         if (flt == FLT_TRUNCATED) begin
            k = $urandom_range(1, frame.size());
            while (frame.size() > k) begin
               void'(frame.pop_back());
            end
         end
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while (take_break()) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data_byte  <= b;
      req_final_byte <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame.size(); i++) begin
         send_byte(frame[i], i == frame.size() - 1);
      end
   endtask

   task automatic write_csr(input logic index, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // wait until every verdict word is back and the pipe is empty
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [63:0] chars;
      logic [3:0]  len;
      logic [63:0] data;
      string       txt;
      int          sent;
      fault_kind   flt;
      int          r;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = '0;
      req_final_byte = 1'b0;
      csr_valid      = 1'b0;
      csr_index      = CSR_VERSION_CHARS;
      csr_data       = '0;
      cur_chars      = '0;
      cur_len        = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: a clean message with an empty begin string, then lone final bytes
      build_message(FLT_NONE, 0);
      send_frame();
      frame = {8'h00};
      send_frame();
      frame = {8'hFF};
      send_frame();
      frame = {CHAR_SOH};
      send_frame();
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               chars = random_text(1'b0);
               len   = 8;
            end
            1: begin
               chars = '1;
               len   = 0;
            end
            2: begin
               chars = random_text(1'b1);
               len   = 15;
            end
            3: begin
               txt   = "FIX.4.4";
               chars = '0;
               for (int i = 0; i < txt.len(); i++) begin
                  chars[8*i +: 8] = txt[i];
               end
               len = 4'(txt.len());
            end
            4: begin
               chars = random_text(1'b0);
               len   = 9;
            end
            default: begin
               chars = random_text(1'($urandom_range(0, 1)));
               len   = 4'($urandom_range(1, 8));
            end
         endcase
         // upper bits of the length word are don't-care
         data      = {$urandom(), $urandom()};
         data[3:0] = len;
         write_csr(CSR_VERSION_CHARS, chars);
         write_csr(CSR_VERSION_LENGTH, data);
         @(negedge clock);
         csr_valid <= 1'b0;
         cur_chars = chars;
         cur_len   = len;

         sent = 0;
         while (sent < PHASE_BYTES) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
               flt = FLT_NONE;
            end else if (r < 88) begin
               flt = fault_kind'($urandom_range(FLT_BAD_VERSION, FLT_TRUNCATED));
            end else begin
               flt = FLT_NOISE;
            end
            build_message(flt, 0);
            send_frame();
            sent += frame.size();
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/fixv_pkg.sv
rtl/fixv_parse.sv
rtl/fix_message_validator.sv
rtl/fixv_checker.sv
tb/sv/fixv_verdict_checker.sv
tb/sv/tb.sv
